// ===== hw/rtl/mvt_pkg.sv =====
// Shared types and constants for the 4x4 matrix-vector transform.
// Used by the configuration file, the row pipeline and the top level.
package mvt_pkg;

	// Widths of the signed Q16.16 format and its intermediate sums.
	localparam int WORD_W    = 32;
	localparam int FRAC_W    = 16;
	localparam int PROD_W    = 2 * WORD_W;
	localparam int PAIR_W    = PROD_W + 1;
	localparam int SUM_W     = PROD_W + 2;
	localparam int DIM       = 4;
	localparam int CFG_W     = 64;
	localparam int CFG_IDX_W = 4;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_ROW0_COLS01 = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ROW0_COLS23 = 4'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ROW1_COLS01 = 4'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ROW1_COLS23 = 4'd3;
	localparam logic [CFG_IDX_W-1:0] REG_ROW2_COLS01 = 4'd4;
	localparam logic [CFG_IDX_W-1:0] REG_ROW2_COLS23 = 4'd5;
	localparam logic [CFG_IDX_W-1:0] REG_ROW3_COLS01 = 4'd6;
	localparam logic [CFG_IDX_W-1:0] REG_ROW3_COLS23 = 4'd7;

	typedef logic signed [WORD_W-1:0] word_t;

	// One matrix row: four coefficients, column 0 first.
	typedef word_t [DIM-1:0] row_t;

	// Per-stage load enables of the pipeline.
	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
		logic s4;
	} adv_t;

endpackage

// ===== hw/rtl/mvt_cfg_regs.sv =====
// Configuration register file holding the 4x4 matrix.
// Depends on mvt_pkg for the register indexes and row type.
module mvt_cfg_regs import mvt_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 wr_en,
	input  logic [CFG_IDX_W-1:0] wr_index,
	input  logic [CFG_W-1:0]     wr_data,
	output row_t                 row0,
	output row_t                 row1,
	output row_t                 row2,
	output row_t                 row3
);

	logic [CFG_W-1:0] r0c01_q, r0c23_q, r1c01_q, r1c23_q;
	logic [CFG_W-1:0] r2c01_q, r2c23_q, r3c01_q, r3c23_q;

	// Register writes; indexes beyond the list are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			r0c01_q <= '0;
			r0c23_q <= '0;
			r1c01_q <= '0;
			r1c23_q <= '0;
			r2c01_q <= '0;
			r2c23_q <= '0;
			r3c01_q <= '0;
			r3c23_q <= '0;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_ROW0_COLS01: r0c01_q <= wr_data;
				REG_ROW0_COLS23: r0c23_q <= wr_data;
				REG_ROW1_COLS01: r1c01_q <= wr_data;
				REG_ROW1_COLS23: r1c23_q <= wr_data;
				REG_ROW2_COLS01: r2c01_q <= wr_data;
				REG_ROW2_COLS23: r2c23_q <= wr_data;
				REG_ROW3_COLS01: r3c01_q <= wr_data;
				REG_ROW3_COLS23: r3c23_q <= wr_data;
				default: ;
			endcase
		end
	end

	// Low word of each register is the even column, high word the odd one.
	assign row0 = {r0c23_q[CFG_W-1:WORD_W], r0c23_q[WORD_W-1:0],
		r0c01_q[CFG_W-1:WORD_W], r0c01_q[WORD_W-1:0]};
	assign row1 = {r1c23_q[CFG_W-1:WORD_W], r1c23_q[WORD_W-1:0],
		r1c01_q[CFG_W-1:WORD_W], r1c01_q[WORD_W-1:0]};
	assign row2 = {r2c23_q[CFG_W-1:WORD_W], r2c23_q[WORD_W-1:0],
		r2c01_q[CFG_W-1:WORD_W], r2c01_q[WORD_W-1:0]};
	assign row3 = {r3c23_q[CFG_W-1:WORD_W], r3c23_q[WORD_W-1:0],
		r3c01_q[CFG_W-1:WORD_W], r3c01_q[WORD_W-1:0]};

endmodule

// ===== hw/rtl/mvt_row_pipe.sv =====
// Four-stage datapath for one matrix row: multiply, pair add, final add,
// shift and saturate. Depends on mvt_pkg; stage enables come from the top.
module mvt_row_pipe import mvt_pkg::*; (
	input  logic  clk,
	input  adv_t  adv,
	input  row_t  coef,
	input  word_t vx,
	input  word_t vy,
	input  word_t vz,
	input  word_t vw,
	output word_t result,
	output logic  sat
);

	logic signed [PROD_W-1:0] p0_s1, p1_s1, p2_s1, p3_s1;
	logic signed [PAIR_W-1:0] a01_s2, a23_s2;
	logic signed [SUM_W-1:0]  sum_s3;
	word_t                    res_s4;
	logic                     sat_s4;

	logic signed [SUM_W-FRAC_W-1:0] shifted;
	logic                           fits;
	word_t                          clamped;

	// Stage 1: exact signed 32x32 products.
	always_ff @(posedge clk) begin
		if (adv.s1) begin
			p0_s1 <= PROD_W'(coef[0]) * PROD_W'(vx);
			p1_s1 <= PROD_W'(coef[1]) * PROD_W'(vy);
			p2_s1 <= PROD_W'(coef[2]) * PROD_W'(vz);
			p3_s1 <= PROD_W'(coef[3]) * PROD_W'(vw);
		end
	end

	// Stage 2: two pair sums, one bit wider.
	always_ff @(posedge clk) begin
		if (adv.s2) begin
			a01_s2 <= {p0_s1[PROD_W-1], p0_s1} + {p1_s1[PROD_W-1], p1_s1};
			a23_s2 <= {p2_s1[PROD_W-1], p2_s1} + {p3_s1[PROD_W-1], p3_s1};
		end
	end

	// Stage 3: exact row sum.
	always_ff @(posedge clk) begin
		if (adv.s3) begin
			sum_s3 <= {a01_s2[PAIR_W-1], a01_s2} + {a23_s2[PAIR_W-1], a23_s2};
		end
	end

	// Floor shift, then clamp when the upper bits are not a sign extension.
	always_comb begin
		shifted = sum_s3[SUM_W-1:FRAC_W];
		fits    = (&shifted[SUM_W-FRAC_W-1:WORD_W-1]) ||
			!(|shifted[SUM_W-FRAC_W-1:WORD_W-1]);
		if (fits) begin
			clamped = shifted[WORD_W-1:0];
		end else if (sum_s3[SUM_W-1]) begin
			clamped = {1'b1, {(WORD_W-1){1'b0}}};
		end else begin
			clamped = {1'b0, {(WORD_W-1){1'b1}}};
		end
	end

	// Stage 4: output register.
	always_ff @(posedge clk) begin
		if (adv.s4) begin
			res_s4 <= clamped;
			sat_s4 <= !fits;
		end
	end

	assign result = res_s4;
	assign sat    = sat_s4;

endmodule

// ===== hw/rtl/matrix4_vector_transform_unit.sv =====
// 4x4 matrix times 4-vector transform, signed Q16.16, saturating.
// Throughput: one vector per cycle while in_stall is low; the pipeline of four
// register stages (multiply, pair add, final add, saturate) takes a new word
// every cycle in which the input is not stalled.
// A stalled output only holds back stages that have no bubble in front.
// Reset clears the stage valid bits and the matrix registers to zero.
module matrix4_vector_transform_unit import mvt_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  word_t                in_x,
	input  word_t                in_y,
	input  word_t                in_z,
	input  word_t                in_w,
	output logic                 out_valid,
	input  logic                 out_stall,
	output word_t                out_x,
	output word_t                out_y,
	output word_t                out_z,
	output word_t                out_w,
	output logic                 saturated,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	row_t  row0, row1, row2, row3;
	adv_t  adv;
	logic  v_s1, v_s2, v_s3, v_s4;
	logic  sat0, sat1, sat2, sat3;

	// Configuration writes are always taken.
	assign cfg_ready = 1'b1;

	mvt_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.row0     (row0),
		.row1     (row1),
		.row2     (row2),
		.row3     (row3)
	);

	// A stage loads when it is empty or the next stage loads too.
	always_comb begin
		adv.s4 = !v_s4 || !out_stall;
		adv.s3 = !v_s3 || adv.s4;
		adv.s2 = !v_s2 || adv.s3;
		adv.s1 = !v_s1 || adv.s2;
	end

	assign in_stall = !adv.s1;

	// Valid bits travel with the data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (adv.s1) v_s1 <= in_valid;
			if (adv.s2) v_s2 <= v_s1;
			if (adv.s3) v_s3 <= v_s2;
			if (adv.s4) v_s4 <= v_s3;
		end
	end

	// One datapath per matrix row.
	mvt_row_pipe u_row0 (
		.clk (clk), .adv (adv), .coef (row0),
		.vx (in_x), .vy (in_y), .vz (in_z), .vw (in_w),
		.result (out_x), .sat (sat0)
	);

	mvt_row_pipe u_row1 (
		.clk (clk), .adv (adv), .coef (row1),
		.vx (in_x), .vy (in_y), .vz (in_z), .vw (in_w),
		.result (out_y), .sat (sat1)
	);

	mvt_row_pipe u_row2 (
		.clk (clk), .adv (adv), .coef (row2),
		.vx (in_x), .vy (in_y), .vz (in_z), .vw (in_w),
		.result (out_z), .sat (sat2)
	);

	mvt_row_pipe u_row3 (
		.clk (clk), .adv (adv), .coef (row3),
		.vx (in_x), .vy (in_y), .vz (in_z), .vw (in_w),
		.result (out_w), .sat (sat3)
	);

	assign out_valid = v_s4;
	assign saturated = sat0 || sat1 || sat2 || sat3;

	// An accepted word always lands in the first stage.
	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> v_s1)
		else $error("accepted word did not enter stage 1");

	// The input is held off only when every stage holds a word.
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (v_s1 && v_s2 && v_s3 && v_s4 && out_stall))
		else $error("input stalled with a bubble in the pipeline");

	// A delivered word with nothing behind it leaves the output empty.
	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !v_s3 |=> !out_valid)
		else $error("output word repeated after delivery");

endmodule

// ===== tb/matrix4_vector_transform_checker.sv =====
`timescale 1ns / 1ps
// Checker for the 4x4 matrix-vector transform: mirrors the matrix registers,
// predicts every output word from the accepted vectors and compares them.
// Depends on mvt_pkg for the word and row types and the register indexes.
module matrix4_vector_transform_checker import mvt_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic                 in_stall,
	input  word_t                in_x,
	input  word_t                in_y,
	input  word_t                in_z,
	input  word_t                in_w,
	input  logic                 out_valid,
	input  logic                 out_stall,
	input  word_t                out_x,
	input  word_t                out_y,
	input  word_t                out_z,
	input  word_t                out_w,
	input  logic                 saturated,
	input  logic                 cfg_valid,
	input  logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	output int                   fail_count,
	output int                   expected_left
);

	// Full range of the sum after the fraction shift, and the clamp values.
	localparam int                    ACC_W     = SUM_W + 1;
	localparam logic signed [ACC_W-1:0] ACC_MAX = 67'sd2147483647;
	localparam logic signed [ACC_W-1:0] ACC_MIN = -67'sd2147483648;
	localparam word_t                 WORD_MAX  = 32'sh7FFF_FFFF;
	localparam word_t                 WORD_MIN  = 32'sh8000_0000;

	// One transformed vector: element 0 is out_x.
	typedef struct packed {
		row_t elem;
		logic sat;
	} transform_t;

	row_t       matrix [DIM];
	transform_t transform_q [$];
	string      field_name [DIM] = '{"out_x", "out_y", "out_z", "out_w"};

	// Exact dot product of one row with the vector, floored to Q16.16 and clamped.
	function automatic word_t row_dot(input row_t coeffs, input row_t vec,
			output logic clamped);
		logic signed [ACC_W-1:0] acc;
		logic signed [PROD_W-1:0] prod;
		int c;
		acc = '0;
		clamped = 1'b0;
		for (c = 0; c < DIM; c++) begin
			prod = PROD_W'($signed(coeffs[c])) * PROD_W'($signed(vec[c]));
			acc = acc + ACC_W'(prod);
		end
		acc = acc >>> FRAC_W;
		if (acc > ACC_MAX) begin
			clamped = 1'b1;
			return WORD_MAX;
		end
		if (acc < ACC_MIN) begin
			clamped = 1'b1;
			return WORD_MIN;
		end
		return acc[WORD_W-1:0];
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		transform_t got;
		transform_t want;
		row_t vec;
		logic clamped;
		logic bad;
		int r;
		int col;
		if (!arst_n) begin
			for (r = 0; r < DIM; r++)
				matrix[r] = '0;
			transform_q.delete();
			fail_count <= 0;
			expected_left <= 0;
		end else begin
			// Compare an accepted output word with the oldest prediction.
			if (out_valid && !out_stall) begin
				got.elem[0] = out_x;
				got.elem[1] = out_y;
				got.elem[2] = out_z;
				got.elem[3] = out_w;
				got.sat = saturated;
				if (transform_q.size() == 0) begin
					$display("%0t: unexpected output word x=%h y=%h z=%h w=%h sat=%b",
						$time, out_x, out_y, out_z, out_w, saturated);
					fail_count <= fail_count + 1;
				end else begin
					want = transform_q.pop_front();
					bad = 1'b0;
					for (r = 0; r < DIM; r++) begin
						if (got.elem[r] !== want.elem[r]) begin
							$display("%0t: %s expected %h actual %h", $time,
								field_name[r], want.elem[r], got.elem[r]);
							bad = 1'b1;
						end
					end
					if (got.sat !== want.sat) begin
						$display("%0t: saturated expected %b actual %b", $time,
							want.sat, got.sat);
						bad = 1'b1;
					end
					if (bad)
						fail_count <= fail_count + 1;
				end
			end

			// Predict the result of an accepted vector with the current matrix.
			if (in_valid && !in_stall) begin
				vec[0] = in_x;
				vec[1] = in_y;
				vec[2] = in_z;
				vec[3] = in_w;
				want.sat = 1'b0;
				for (r = 0; r < DIM; r++) begin
					want.elem[r] = row_dot(matrix[r], vec, clamped);
					want.sat = want.sat | clamped;
				end
				transform_q.push_back(want);
			end

			// Each row takes two registers; the lower one holds columns 0 and 1.
			// Indexes past the last register are ignored.
			if (cfg_valid && cfg_ready && cfg_index <= REG_ROW3_COLS23) begin
				r = int'(cfg_index) / 2;
				col = (int'(cfg_index) % 2) * 2;
				matrix[r][col] = cfg_data[WORD_W-1:0];
				matrix[r][col + 1] = cfg_data[CFG_W-1:WORD_W];
			end

			expected_left <= transform_q.size();
		end
	end

endmodule

// ===== tb/matrix4_vector_transform_unit_tb.sv =====
`timescale 1ns / 1ps
// Testbench top for matrix4_vector_transform_unit: drives matrices and vectors
// with random idling and a long output hold, and reports the verdict.
// Depends on mvt_pkg and matrix4_vector_transform_checker.
module matrix4_vector_transform_unit_tb;
	import mvt_pkg::*;

	localparam int    LATENCY       = 4;
	localparam int    HOLD_CYCLES   = 120;
	localparam int    QUIET_LIMIT   = 2000;
	localparam int    NUM_PHASES    = 8;
	localparam int    PHASE_VECTORS = 230;
	localparam word_t WORD_MAX      = 32'sh7FFF_FFFF;
	localparam word_t WORD_MIN      = 32'sh8000_0000;
	localparam word_t ONE           = 32'sh0001_0000;
	localparam word_t LSB           = 32'sh0000_0001;

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 in_valid  = 1'b0;
	logic                 in_stall;
	word_t                in_x      = '0;
	word_t                in_y      = '0;
	word_t                in_z      = '0;
	word_t                in_w      = '0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	word_t                out_x;
	word_t                out_y;
	word_t                out_z;
	word_t                out_w;
	logic                 saturated;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]     cfg_data  = '0;

	int   fail_count;
	int   expected_left;
	int   quiet_cycles = 0;
	bit   idle_on = 1'b0;
	bit   hold_request = 1'b0;
	row_t coeffs [DIM];

	matrix4_vector_transform_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_x      (in_x),
		.in_y      (in_y),
		.in_z      (in_z),
		.in_w      (in_w),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_x     (out_x),
		.out_y     (out_y),
		.out_z     (out_z),
		.out_w     (out_w),
		.saturated (saturated),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	matrix4_vector_transform_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.in_x          (in_x),
		.in_y          (in_y),
		.in_z          (in_z),
		.in_w          (in_w),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.out_x         (out_x),
		.out_y         (out_y),
		.out_z         (out_z),
		.out_w         (out_w),
		.saturated     (saturated),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.fail_count    (fail_count),
		.expected_left (expected_left)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Abort when no word moves on any channel for too long.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
				(cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("FAILURE");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Output side: random stall bursts, plus one long hold on request.
	initial begin
		forever begin
			@(posedge clk);
			if (hold_request) begin
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				out_stall <= 1'b0;
				hold_request = 1'b0;
			end else if (idle_on && $urandom_range(0, 7) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 12)) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	// Full-range words and words within +-8.0 in equal shares, some corner values.
	function automatic word_t pick_value();
		int unsigned sel;
		sel = $urandom_range(0, 9);
		if (sel < 4)
			return word_t'($urandom);
		if (sel < 8)
			return word_t'($urandom) >>> 12;
		case ($urandom_range(0, 6))
			0: return WORD_MAX;
			1: return WORD_MIN;
			2: return ONE;
			3: return -ONE;
			4: return LSB;
			5: return -LSB;
			default: return '0;
		endcase
	endfunction

	// Offer one vector and hold it until the block takes it.
	task automatic send_vector(input word_t x, input word_t y, input word_t z,
			input word_t w);
		if (idle_on && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_x <= x;
		in_y <= y;
		in_z <= z;
		in_w <= w;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic send_random_vector();
		send_vector(pick_value(), pick_value(), pick_value(), pick_value());
	endtask

	// Let the pipeline drain, then write all eight registers of coeffs and one index past them.
	task automatic load_matrix();
		int idx;
		int row;
		int col;
		in_valid <= 1'b0;
		do @(posedge clk); while (expected_left != 0);
		repeat (LATENCY) @(posedge clk);
		for (idx = int'(REG_ROW0_COLS01); idx <= int'(REG_ROW3_COLS23); idx++) begin
			row = idx / 2;
			col = (idx % 2) * 2;
			cfg_valid <= 1'b1;
			cfg_index <= CFG_IDX_W'(idx);
			cfg_data <= {coeffs[row][col + 1], coeffs[row][col]};
			do @(posedge clk); while (!cfg_ready);
		end
		// A write past the last register must leave the matrix alone.
		cfg_index <= CFG_IDX_W'($urandom_range(int'(REG_ROW3_COLS23) + 1,
			(1 << CFG_IDX_W) - 1));
		cfg_data <= {$urandom, $urandom};
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	task automatic fill_matrix(input word_t value);
		int r;
		for (r = 0; r < DIM; r++)
			coeffs[r] = {DIM{value}};
	endtask

	task automatic fill_identity();
		int r;
		fill_matrix('0);
		for (r = 0; r < DIM; r++)
			coeffs[r][r] = ONE;
	endtask

	initial begin : stimulus
		int p;
		int n;
		int r;
		int c;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Matrix after reset is all zero.
		send_vector(WORD_MAX, WORD_MIN, -LSB, LSB);

		// Identity: exact extremes pass through without clamping.
		fill_identity();
		load_matrix();
		send_vector(WORD_MAX, WORD_MIN, '0, -LSB);
		send_vector(LSB, -LSB, ONE, -ONE);

		// Smallest coefficients: the shift floors toward minus infinity.
		fill_matrix(LSB);
		load_matrix();
		send_vector(-LSB, '0, '0, '0);
		send_vector(LSB, '0, '0, '0);
		send_vector(WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX);

		// Largest positive coefficients: overflow both ways and a cancelling sum.
		fill_matrix(WORD_MAX);
		load_matrix();
		send_vector(WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX);
		send_vector(WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN);
		send_vector(WORD_MAX, WORD_MIN, '0, '0);

		// Most negative coefficients: the sum reaches its largest possible value.
		fill_matrix(WORD_MIN);
		load_matrix();
		send_vector(WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN);
		send_vector(WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX);

		// Row 0 clamps high then passes, row 1 clamps low then high, row 2 high, row 3 is zero.
		coeffs[0] = {DIM{WORD_MAX}};
		coeffs[1] = {DIM{WORD_MIN}};
		coeffs[2] = {ONE, -ONE, ONE, ONE};
		coeffs[3] = '0;
		load_matrix();
		send_vector(WORD_MAX, WORD_MAX, ONE, '0);
		send_vector(-ONE, LSB, WORD_MIN, WORD_MAX);

		// Random phases, each with a fresh matrix of its own flavor.
		for (p = 0; p < NUM_PHASES; p++) begin
			for (r = 0; r < DIM; r++) begin
				for (c = 0; c < DIM; c++) begin
					case (p % 3)
						0: coeffs[r][c] = word_t'($urandom) >>> 12;
						1: coeffs[r][c] = pick_value();
						default: coeffs[r][c] = word_t'($urandom);
					endcase
				end
			end
			load_matrix();
			idle_on = (p % 2 == 0) && (p != NUM_PHASES - 1);
			if (p == 1)
				hold_request = 1'b1;
			for (n = 0; n < PHASE_VECTORS; n++)
				send_random_vector();
		end

		// Drain and let any stray output word show up.
		in_valid <= 1'b0;
		do @(posedge clk); while (expected_left != 0);
		repeat (2 * LATENCY) @(posedge clk);
		if (fail_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
